FILE: src/compacting_array_store_defines.svh
// assertion macros used by the checker file of the compacting array store
`ifndef COMPACTING_ARRAY_STORE_DEFINES_SVH
`define COMPACTING_ARRAY_STORE_DEFINES_SVH

// condition holds on every clock edge out of reset
`define CAS_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CAS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define CAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/cas_pkg.sv
// shared types and codes of the compacting array store
`default_nettype none

package cas_pkg;

  // payload field widths
  localparam int OP_W      = 2;
  localparam int KEY_IN_W  = 32;
  localparam int STATUS_W  = 2;
  localparam int POS_W     = 4;
  localparam int FILL_W    = 5;

  // parameter defaults
  localparam int DEF_CAPACITY  = 16;
  localparam int DEF_KEY_WIDTH = 32;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  // operation codes
  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_SEARCH = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;

  // result status codes
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_ABSENT = 2'd2;

endpackage

`default_nettype wire

FILE: src/compacting_array_store.sv
// compacting array store: unsorted key memory with insert, search and remove
//
//   channel | direction | words
//   in_     | input     | op, key_value
//   out_    | output    | status, position, fill_count
//
// One word at a time. Insert appends in a single write, and an unused op code
// goes straight to the result. Search and remove scan the entries in order: the
// single read port of the key memory gives one entry a cycle, first for the scan
// up to the match, then for the shift down of the entries after it. The result
// register holds a word until taken; a stalled result holds the next operation
// in its final state.
// Reset clears the fill count, state and valid flags; memory contents need no clearing.
`default_nettype none

module compacting_array_store #(
  parameter int CAPACITY  = cas_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = cas_pkg::DEF_KEY_WIDTH
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [cas_pkg::OP_W-1:0]     in_op,
  input  wire  [cas_pkg::KEY_IN_W-1:0] in_key_value,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [cas_pkg::STATUS_W-1:0] out_status,
  output logic [cas_pkg::POS_W-1:0]    out_position,
  output logic [cas_pkg::FILL_W-1:0]   out_fill_count
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [KEY_WIDTH-1:0] key_t;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INSERT = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]      state_r, state_nxt;
  cas_pkg::op_t    op_r, op_nxt;
  key_t            key_r, key_nxt;
  cnt_t            cnt_r, cnt_nxt;
  cnt_t            ptr_r, ptr_nxt;
  logic            rd_vld_r, rd_vld_nxt;
  idx_t            rd_idx_r, rd_idx_nxt;
  cas_pkg::status_t res_status_r, res_status_nxt;
  idx_t            res_pos_r, res_pos_nxt;
  logic            out_valid_r, out_valid_nxt;
  cas_pkg::status_t out_status_r, out_status_nxt;
  idx_t            out_pos_r, out_pos_nxt;
  cnt_t            out_cnt_r, out_cnt_nxt;

  // key memory ports
  key_t            mem [CAPACITY];
  key_t            rd_data_r;
  logic            mem_we;
  idx_t            mem_waddr;
  key_t            mem_wdata;
  logic            mem_re;
  idx_t            mem_raddr;

  logic [63:0]     key_ext;
  key_t            key_in;
  logic            hit;
  idx_t            ptr_idx;

  // keep the low key bits only
  assign key_ext = 64'(in_key_value);
  assign key_in  = key_ext[KEY_WIDTH-1:0];

  assign ptr_idx  = ptr_r[IDX_W-1:0];
  assign hit      = rd_vld_r && (rd_data_r == key_r);
  assign in_ready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    cnt_nxt        = cnt_r;
    ptr_nxt        = ptr_r;
    rd_vld_nxt     = rd_vld_r;
    rd_idx_nxt     = rd_idx_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_cnt_nxt    = out_cnt_r;
    mem_we         = 1'b0;
    mem_waddr      = rd_idx_r;
    mem_wdata      = rd_data_r;
    mem_re         = 1'b0;
    mem_raddr      = ptr_idx;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_op;
          key_nxt        = key_in;
          ptr_nxt        = '0;
          rd_vld_nxt     = 1'b0;
          res_status_nxt = cas_pkg::ST_OK;
          res_pos_nxt    = '0;
          unique case (in_op)
            cas_pkg::OP_INSERT: state_nxt = S_INSERT;
            cas_pkg::OP_SEARCH,
            cas_pkg::OP_REMOVE: state_nxt = S_SCAN;
            default:            state_nxt = S_DONE;
          endcase
        end
      end

      // append at the end when there is room
      S_INSERT: begin
        if (cnt_r < CAP_CNT) begin
          mem_we         = 1'b1;
          mem_waddr      = cnt_r[IDX_W-1:0];
          mem_wdata      = key_r;
          res_status_nxt = cas_pkg::ST_OK;
          res_pos_nxt    = cnt_r[IDX_W-1:0];
          cnt_nxt        = cnt_r + 1'b1;
        end else begin
          res_status_nxt = cas_pkg::ST_FULL;
          res_pos_nxt    = '0;
        end
        state_nxt = S_DONE;
      end

      // one read issued and one compare per cycle
      S_SCAN: begin
        if (hit) begin
          res_status_nxt = cas_pkg::ST_OK;
          res_pos_nxt    = rd_idx_r;
          rd_vld_nxt     = 1'b0;
          if (op_r == cas_pkg::OP_REMOVE) begin
            ptr_nxt   = CNT_W'(rd_idx_r) + 1'b1;
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (ptr_r < cnt_r) begin
          mem_re     = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = ptr_idx;
          ptr_nxt    = ptr_r + 1'b1;
        end else begin
          rd_vld_nxt     = 1'b0;
          res_status_nxt = cas_pkg::ST_ABSENT;
          res_pos_nxt    = '0;
          state_nxt      = S_DONE;
        end
      end

      // read entry i+1, write it back at i in the following cycle
      S_SHIFT: begin
        if (rd_vld_r) begin
          mem_we = 1'b1;
        end
        if (ptr_r < cnt_r) begin
          mem_re     = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = ptr_idx - 1'b1;
          ptr_nxt    = ptr_r + 1'b1;
        end else begin
          rd_vld_nxt = 1'b0;
          if (!rd_vld_r) begin
            cnt_nxt   = cnt_r - 1'b1;
            state_nxt = S_DONE;
          end
        end
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pos_nxt    = res_pos_r;
          out_cnt_nxt    = cnt_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    ptr_r        <= ptr_nxt;
    rd_idx_r     <= rd_idx_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  // key memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_position   = cas_pkg::POS_W'(out_pos_r);
  assign out_fill_count = cas_pkg::FILL_W'(out_cnt_r);

endmodule

`default_nettype wire

FILE: src/cas_checker.sv
// port-level checks on the compacting array store, bound to the top level
`default_nettype none
`include "compacting_array_store_defines.svh"

module cas_checker #(
  parameter int CAPACITY = cas_pkg::DEF_CAPACITY
) (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [cas_pkg::STATUS_W-1:0]  out_status,
  input wire [cas_pkg::POS_W-1:0]     out_position,
  input wire [cas_pkg::FILL_W-1:0]    out_fill_count
);

  localparam logic [cas_pkg::FILL_W-1:0] FULL_CNT = cas_pkg::FILL_W'(CAPACITY);

  // a stalled result word holds
  `CAS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_position) && $stable(out_fill_count), "stalled result changed")

  // one word in work at a time
  `CAS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready stayed high after accept")

  // failures carry position zero
  `CAS_ASSERT_IMPL(a_pos_zero, out_valid && (out_status != cas_pkg::ST_OK), out_position == '0, "nonzero position on failure")

  // full only at capacity
  `CAS_ASSERT_IMPL(a_full_count, out_valid && (out_status == cas_pkg::ST_FULL), out_fill_count == FULL_CNT, "full reported below capacity")

  // only defined status codes
  `CAS_ASSERT_HOLDS(a_status_code, !out_valid || (out_status == cas_pkg::ST_OK) || (out_status == cas_pkg::ST_FULL) || (out_status == cas_pkg::ST_ABSENT), "undefined status code")

endmodule

bind compacting_array_store cas_checker #(
  .CAPACITY(CAPACITY)
) u_cas_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_position   (out_position),
  .out_fill_count (out_fill_count)
);

`default_nettype wire
